// ----- rtl/smr_pkg.sv -----
// Package: shared constants, codes and types of the segment plan read mapper.
package smr_pkg;

  localparam int MAX_SEGMENTS = 64;
  localparam int OFFSET_BITS  = 48;

  localparam int FIELD_W     = 48;
  localparam int BYTES_W     = 32;
  localparam int SIZE_W      = 48;
  localparam int COUNT_W     = 7;
  localparam int INDEX_W     = 6;
  localparam int FUNC_W      = 2;
  localparam int KIND_W      = 2;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 48;

  localparam int ADDR_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int IDX_W  = $clog2(MAX_SEGMENTS + 1);

  localparam logic [FUNC_W-1:0] FUNC_LOAD        = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_READ        = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ_CURSOR = 2'd2;

  localparam logic [KIND_W-1:0] KIND_ZERO  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SRC   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] REG_DEST_SIZE     = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SEGMENT_COUNT = 1'd1;

  typedef logic [OFFSET_BITS-1:0] off_t;

  typedef struct packed {
    logic pad;
    off_t src;
    off_t len;
    off_t dst;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic [SIZE_W-1:0]  dest_size;
    logic [COUNT_W-1:0] segment_count;
  } cfg_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    entry_t            wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [FIELD_W-1:0] src_address;
    logic [BYTES_W-1:0] out_position;
    logic [BYTES_W-1:0] piece_bytes;
    logic [BYTES_W-1:0] total_bytes;
    logic               last;
  } piece_t;

  localparam piece_t EMPTY_PIECE = '{
    kind: KIND_EMPTY, src_address: '0, out_position: '0,
    piece_bytes: '0, total_bytes: '0, last: 1'b1
  };

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLIP1,
    ST_CLIP2,
    ST_FETCH,
    ST_LOCAL,
    ST_AVAIL,
    ST_TAKE,
    ST_PUSH,
    ST_FLUSH
  } walk_state_t;

endpackage

// ----- rtl/smr_in_if.sv -----
// Interface: request channel carrying table loads and read requests.
interface smr_in_if;
  import smr_pkg::*;

  logic               valid;
  logic               ready;
  logic [FUNC_W-1:0]  func;
  logic [INDEX_W-1:0] entry_index;
  logic [FIELD_W-1:0] entry_dst_offset;
  logic [FIELD_W-1:0] entry_length;
  logic [FIELD_W-1:0] entry_src_offset;
  logic               entry_is_pad;
  logic [FIELD_W-1:0] req_offset;
  logic [BYTES_W-1:0] req_bytes;

  modport source (
    output valid, func, entry_index, entry_dst_offset, entry_length,
           entry_src_offset, entry_is_pad, req_offset, req_bytes,
    input  ready
  );

  modport sink (
    input  valid, func, entry_index, entry_dst_offset, entry_length,
           entry_src_offset, entry_is_pad, req_offset, req_bytes,
    output ready
  );
endinterface

// ----- rtl/smr_out_if.sv -----
// Interface: piece channel carrying the mapped read pieces.
interface smr_out_if;
  import smr_pkg::*;

  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  piece_kind;
  logic [FIELD_W-1:0] src_address;
  logic [BYTES_W-1:0] out_position;
  logic [BYTES_W-1:0] piece_bytes;
  logic [BYTES_W-1:0] total_bytes;
  logic               last;

  modport source (
    output valid, piece_kind, src_address, out_position, piece_bytes,
           total_bytes, last,
    input  ready
  );

  modport sink (
    input  valid, piece_kind, src_address, out_position, piece_bytes,
           total_bytes, last,
    output ready
  );
endinterface

// ----- rtl/smr_ram.sv -----
// Generic single write, single read RAM with registered read data.
module smr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// ----- rtl/smr_walker.sv -----
// Segment walker: decodes requests, walks the table memory and emits pieces.
module smr_walker (
  input  logic              clk,
  input  logic              rst,
  input  smr_pkg::cfg_t     cfg,
  smr_in_if.sink            request,
  smr_out_if.source         piece,
  output smr_pkg::mem_req_t mem_req,
  input  smr_pkg::entry_t   mem_rdata,
  output logic              busy
);
  import smr_pkg::*;

  walk_state_t state, state_next;

  off_t               offset;
  off_t               tsize;
  off_t               diff;
  off_t               local_off;
  off_t               avail;
  off_t               src_addr;
  off_t               ent_len;
  off_t               ent_src;
  off_t               cursor;
  logic               ent_pad;
  logic               cursor_mode;
  logic               empty_req;
  logic               rem_le;
  logic               avail_le;
  logic [BYTES_W-1:0] req_max;
  logic [BYTES_W-1:0] remaining;
  logic [BYTES_W-1:0] done;
  logic [BYTES_W-1:0] take;
  logic [IDX_W-1:0]   idx;
  logic [IDX_W-1:0]   idx_inc;
  logic [IDX_W-1:0]   count;
  logic               is_read;
  logic               slot_ok;
  logic               out_free;
  logic               push_go;
  logic               out_valid;
  logic               pend_valid;
  piece_t             out_piece;
  piece_t             pend;
  piece_t             cand;

  assign tsize   = off_t'(cfg.dest_size);
  assign count   = (int'(cfg.segment_count) > MAX_SEGMENTS) ? IDX_W'(MAX_SEGMENTS)
                                                            : IDX_W'(cfg.segment_count);
  assign idx_inc = IDX_W'(idx + 1'b1);
  assign is_read = (request.func == FUNC_READ) || (request.func == FUNC_READ_CURSOR);
  assign slot_ok = int'(request.entry_index) < MAX_SEGMENTS;

  always_comb begin
    cand.kind         = ent_pad ? KIND_ZERO : KIND_SRC;
    cand.src_address  = ent_pad ? '0 : FIELD_W'(src_addr);
    cand.out_position = done;
    cand.piece_bytes  = take;
    cand.total_bytes  = BYTES_W'(done + take);
    cand.last         = 1'b0;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (request.valid && is_read) begin
          state_next = ST_CLIP1;
        end
      end
      ST_CLIP1: state_next = ST_CLIP2;
      ST_CLIP2: begin
        if (empty_req || count == '0) begin
          state_next = ST_FLUSH;
        end else begin
          state_next = ST_FETCH;
        end
      end
      ST_FETCH: state_next = ST_LOCAL;
      ST_LOCAL: begin
        if (offset < mem_rdata.dst) begin
          state_next = ST_FLUSH;
        end else begin
          state_next = ST_AVAIL;
        end
      end
      ST_AVAIL: begin
        if (local_off < ent_len) begin
          state_next = ST_TAKE;
        end else if (idx_inc >= count) begin
          state_next = ST_FLUSH;
        end else begin
          state_next = ST_FETCH;
        end
      end
      ST_TAKE: state_next = ST_PUSH;
      ST_PUSH: begin
        if (push_go) begin
          if (rem_le || idx_inc >= count) begin
            state_next = ST_FLUSH;
          end else begin
            state_next = ST_FETCH;
          end
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    request.ready = (state == ST_IDLE);
    busy          = (state != ST_IDLE);
    out_free      = !out_valid || piece.ready;
    push_go       = (state == ST_PUSH) && (!pend_valid || out_free);
    mem_req.we    = (state == ST_IDLE) && request.valid &&
                    (request.func == FUNC_LOAD) && slot_ok;
    mem_req.waddr = ADDR_W'(request.entry_index);
    mem_req.wdata.pad = request.entry_is_pad;
    mem_req.wdata.src = off_t'(request.entry_src_offset);
    mem_req.wdata.len = off_t'(request.entry_length);
    mem_req.wdata.dst = off_t'(request.entry_dst_offset);
    mem_req.re    = (state == ST_FETCH);
    mem_req.raddr = idx[ADDR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
      cursor     <= '0;
    end else begin
      state <= state_next;
      if ((push_go && pend_valid) || (state == ST_FLUSH && out_free)) begin
        out_valid <= 1'b1;
      end else if (piece.ready) begin
        out_valid <= 1'b0;
      end
      if (push_go) begin
        pend_valid <= 1'b1;
      end
      if (state == ST_FLUSH && out_free) begin
        pend_valid <= 1'b0;
        if (cursor_mode) begin
          cursor <= off_t'(cursor + off_t'(done));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        cursor_mode <= (request.func == FUNC_READ_CURSOR);
        offset      <= (request.func == FUNC_READ_CURSOR) ? cursor
                                                          : off_t'(request.req_offset);
        req_max     <= request.req_bytes;
      end
      ST_CLIP1: begin
        diff      <= off_t'(tsize - offset);
        empty_req <= (offset >= tsize) || (req_max == '0);
      end
      ST_CLIP2: begin
        remaining <= (diff < off_t'(req_max)) ? diff[BYTES_W-1:0] : req_max;
        done      <= '0;
        idx       <= '0;
      end
      ST_LOCAL: begin
        local_off <= off_t'(offset - mem_rdata.dst);
        ent_len   <= mem_rdata.len;
        ent_src   <= mem_rdata.src;
        ent_pad   <= mem_rdata.pad;
      end
      ST_AVAIL: begin
        avail    <= off_t'(ent_len - local_off);
        src_addr <= off_t'(ent_src + local_off);
        if (local_off >= ent_len) begin
          idx <= idx_inc;
        end
      end
      ST_TAKE: begin
        rem_le   <= off_t'(remaining) <= avail;
        avail_le <= avail <= off_t'(remaining);
        take     <= (off_t'(remaining) <= avail) ? remaining : avail[BYTES_W-1:0];
      end
      ST_PUSH: begin
        if (push_go) begin
          if (pend_valid) begin
            out_piece <= pend;
          end
          pend      <= cand;
          offset    <= off_t'(offset + off_t'(take));
          remaining <= BYTES_W'(remaining - take);
          done      <= BYTES_W'(done + take);
          if (avail_le) begin
            idx <= idx_inc;
          end
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          if (pend_valid) begin
            out_piece <= '{
              kind: pend.kind, src_address: pend.src_address,
              out_position: pend.out_position, piece_bytes: pend.piece_bytes,
              total_bytes: pend.total_bytes, last: 1'b1
            };
          end else begin
            out_piece <= EMPTY_PIECE;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign piece.valid        = out_valid;
  assign piece.piece_kind   = out_piece.kind;
  assign piece.src_address  = out_piece.src_address;
  assign piece.out_position = out_piece.out_position;
  assign piece.piece_bytes  = out_piece.piece_bytes;
  assign piece.total_bytes  = out_piece.total_bytes;
  assign piece.last         = out_piece.last;
endmodule

// ----- rtl/segment_plan_read_mapper_unit.sv -----
// Top level: configuration registers, segment table memory and walker.
// A table load is written into the segment memory as it is accepted. A read first clips
// the request to the destination size, then walks the table one entry at a time through
// the single read port of the segment memory, skipping segments, producing pieces or
// stopping at a gap, and emits the final piece last. Output stalls hold the walk at each piece.
// Reset (synchronous, active high) clears the cursor and the configuration registers.
module segment_plan_read_mapper_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [smr_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [smr_pkg::CFG_DATA_W-1:0]      cfg_data,
  smr_in_if.sink                              request,
  smr_out_if.source                           piece
);
  import smr_pkg::*;

  cfg_t     cfg;
  mem_req_t mem_req;
  entry_t   mem_rdata;
  logic     busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEST_SIZE:     cfg.dest_size     <= cfg_data[SIZE_W-1:0];
        REG_SEGMENT_COUNT: cfg.segment_count <= cfg_data[COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  smr_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_SEGMENTS)
  ) u_table (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (mem_req.raddr),
    .rdata (mem_rdata)
  );

  smr_walker u_walker (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .request   (request),
    .piece     (piece),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata),
    .busy      (busy)
  );

  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    piece.valid && piece.piece_kind == KIND_EMPTY |-> piece.last)
    else $error("empty piece without last");

  a_zero_no_src: assert property (@(posedge clk) disable iff (rst)
    piece.valid && piece.piece_kind == KIND_ZERO |-> piece.src_address == '0)
    else $error("zero fill piece with source address");

  a_read_starts_walk: assert property (@(posedge clk) disable iff (rst)
    request.valid && request.ready &&
    (request.func == FUNC_READ || request.func == FUNC_READ_CURSOR) |=> busy)
    else $error("accepted read did not start a walk");

  a_busy_blocks: assert property (@(posedge clk) disable iff (rst)
    busy |-> !request.ready)
    else $error("request accepted during walk");

  a_total_sum: assert property (@(posedge clk) disable iff (rst)
    piece.valid && piece.piece_kind != KIND_EMPTY |->
    piece.total_bytes == BYTES_W'(piece.out_position + piece.piece_bytes))
    else $error("running total mismatch");
endmodule

// ----- bench/tb.sv -----
// Testbench: drives table loads and reads into the segment plan read mapper, checks each piece.
`timescale 1ns / 1ps

module tb;
  import smr_pkg::*;

  localparam int ITEM_TARGET   = 160;
  localparam int QUIET_ITEMS   = 30;
  localparam int SETTLE_CYCLES = 32;
  localparam int TAIL_CYCLES   = 64;
  localparam int LONG_HOLD     = 250;
  localparam int STALL_LIMIT   = 3000;

  localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;

  typedef enum int {PLAN_FINE, PLAN_WIDE, PLAN_TOP} plan_shape_t;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [INDEX_W-1:0] entry_index;
    logic [FIELD_W-1:0] entry_dst_offset;
    logic [FIELD_W-1:0] entry_length;
    logic [FIELD_W-1:0] entry_src_offset;
    logic               entry_is_pad;
    logic [FIELD_W-1:0] req_offset;
    logic [BYTES_W-1:0] req_bytes;
  } request_t;

  class piece_ledger_t;
    off_t               seg_dst [MAX_SEGMENTS];
    off_t               seg_len [MAX_SEGMENTS];
    off_t               seg_src [MAX_SEGMENTS];
    bit                 seg_pad [MAX_SEGMENTS];
    off_t               cursor;
    logic [SIZE_W-1:0]  size_limit;
    logic [COUNT_W-1:0] seg_count;
    piece_t             pending_pieces[$];
    int                 mismatches;
    int                 pieces_seen;
    int                 loads_seen;
    int                 reads_seen;

    function new();
      foreach (seg_dst[i]) begin
        seg_dst[i] = '0;
        seg_len[i] = '0;
        seg_src[i] = '0;
        seg_pad[i] = 1'b0;
      end
      cursor = '0;
      size_limit = '0;
      seg_count = '0;
      mismatches = 0;
      pieces_seen = 0;
      loads_seen = 0;
      reads_seen = 0;
    endfunction

    function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == REG_DEST_SIZE) begin
        size_limit = val[SIZE_W-1:0];
      end else begin
        seg_count = val[COUNT_W-1:0];
      end
    endfunction

    function int pending();
      return pending_pieces.size();
    endfunction

    function logic [BYTES_W-1:0] map_read(off_t start, logic [BYTES_W-1:0] want);
      off_t               pos_off;
      off_t               rem;
      off_t               local_off;
      off_t               avail;
      off_t               take;
      logic [BYTES_W-1:0] done;
      int                 lim;
      int                 idx;
      int                 n;
      piece_t             held;
      bit                 have;
      lim = (seg_count > MAX_SEGMENTS) ? MAX_SEGMENTS : int'(seg_count);
      pos_off = start;
      done = '0;
      idx = 0;
      n = 0;
      have = 1'b0;
      if (pos_off >= size_limit || want == '0) begin
        pending_pieces.push_back(EMPTY_PIECE);
        return '0;
      end
      rem = size_limit - pos_off;
      if (off_t'(want) < rem) rem = off_t'(want);
      while (idx < lim && !(pos_off < seg_dst[idx] || pos_off - seg_dst[idx] < seg_len[idx]))
        idx++;
      while (rem > 0 && idx < lim && n < MAX_SEGMENTS) begin
        if (pos_off < seg_dst[idx]) break;
        local_off = pos_off - seg_dst[idx];
        if (local_off >= seg_len[idx]) begin
          idx++;
          continue;
        end
        avail = seg_len[idx] - local_off;
        take = (rem < avail) ? rem : avail;
        if (have) pending_pieces.push_back(held);
        held.kind = seg_pad[idx] ? KIND_ZERO : KIND_SRC;
        held.src_address = seg_pad[idx] ? '0 : seg_src[idx] + local_off;
        held.out_position = done;
        held.piece_bytes = take[BYTES_W-1:0];
        held.total_bytes = done + take[BYTES_W-1:0];
        held.last = 1'b0;
        have = 1'b1;
        n++;
        done += take[BYTES_W-1:0];
        pos_off += take;
        rem -= take;
        if (take == avail) idx++;
      end
      if (!have) begin
        pending_pieces.push_back(EMPTY_PIECE);
      end else begin
        held.last = 1'b1;
        pending_pieces.push_back(held);
      end
      return done;
    endfunction

    function void note_request(request_t r);
      logic [BYTES_W-1:0] moved;
      case (r.func)
        FUNC_LOAD: begin
          seg_dst[r.entry_index] = r.entry_dst_offset;
          seg_len[r.entry_index] = r.entry_length;
          seg_src[r.entry_index] = r.entry_src_offset;
          seg_pad[r.entry_index] = r.entry_is_pad;
          loads_seen++;
        end
        FUNC_READ: begin
          moved = map_read(r.req_offset, r.req_bytes);
          reads_seen++;
        end
        FUNC_READ_CURSOR: begin
          moved = map_read(cursor, r.req_bytes);
          cursor += off_t'(moved);
          reads_seen++;
        end
        default: ;
      endcase
    endfunction

    function void flag(string what, logic [63:0] want, logic [63:0] got);
      mismatches++;
      if (mismatches <= 40)
        $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
    endfunction

    function void check_piece(piece_t got);
      piece_t want;
      pieces_seen++;
      if (pending_pieces.size() == 0) begin
        mismatches++;
        if (mismatches <= 40)
          $display("%0t: piece expected none actual kind %0h bytes %0h", $time, got.kind,
                   got.piece_bytes);
        return;
      end
      want = pending_pieces.pop_front();
      if (got.kind !== want.kind) flag("piece_kind", 64'(want.kind), 64'(got.kind));
      if (got.src_address !== want.src_address)
        flag("src_address", 64'(want.src_address), 64'(got.src_address));
      if (got.out_position !== want.out_position)
        flag("out_position", 64'(want.out_position), 64'(got.out_position));
      if (got.piece_bytes !== want.piece_bytes)
        flag("piece_bytes", 64'(want.piece_bytes), 64'(got.piece_bytes));
      if (got.total_bytes !== want.total_bytes)
        flag("total_bytes", 64'(want.total_bytes), 64'(got.total_bytes));
      if (got.last !== want.last) flag("last", 64'(want.last), 64'(got.last));
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  smr_in_if  request();
  smr_out_if piece();

  segment_plan_read_mapper_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .request   (request),
    .piece     (piece)
  );

  piece_ledger_t board;
  bit            quiet;
  bit            hold_ask;
  int            items_sent;
  int            stall_cycles;

  always #2 clk = ~clk;

  function automatic off_t rand48();
    return off_t'({$urandom, $urandom});
  endfunction

  function automatic request_t noise_req(logic [FUNC_W-1:0] f);
    request_t r;
    r.func = f;
    r.entry_index = INDEX_W'($urandom);
    r.entry_dst_offset = rand48();
    r.entry_length = rand48();
    r.entry_src_offset = rand48();
    r.entry_is_pad = 1'($urandom);
    r.req_offset = rand48();
    r.req_bytes = $urandom;
    return r;
  endfunction

  function automatic logic [BYTES_W-1:0] pick_bytes(plan_shape_t shape);
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return $urandom;
      default: return (shape == PLAN_WIDE) ? $urandom : $urandom_range(1, 1500);
    endcase
  endfunction

  task automatic send_item(input request_t r);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      request.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    request.valid <= 1'b1;
    request.func <= r.func;
    request.entry_index <= r.entry_index;
    request.entry_dst_offset <= r.entry_dst_offset;
    request.entry_length <= r.entry_length;
    request.entry_src_offset <= r.entry_src_offset;
    request.entry_is_pad <= r.entry_is_pad;
    request.req_offset <= r.req_offset;
    request.req_bytes <= r.req_bytes;
    @(posedge clk);
    while (request.ready !== 1'b1) @(posedge clk);
    board.note_request(r);
    if (r.func != FUNC_SPARE) items_sent++;
    if (items_sent >= ITEM_TARGET - QUIET_ITEMS) quiet <= 1'b1;
  endtask

  task automatic load_entry(input logic [INDEX_W-1:0] slot, input off_t dst, input off_t len,
                            input off_t src, input logic pad);
    request_t r;
    r = noise_req(FUNC_LOAD);
    r.entry_index = slot;
    r.entry_dst_offset = dst;
    r.entry_length = len;
    r.entry_src_offset = src;
    r.entry_is_pad = pad;
    send_item(r);
  endtask

  task automatic read_at(input off_t offset, input logic [BYTES_W-1:0] bytes);
    request_t r;
    r = noise_req(FUNC_READ);
    r.req_offset = offset;
    r.req_bytes = bytes;
    send_item(r);
  endtask

  task automatic read_from_cursor(input logic [BYTES_W-1:0] bytes);
    request_t r;
    r = noise_req(FUNC_READ_CURSOR);
    r.req_bytes = bytes;
    send_item(r);
  endtask

  task automatic drain(input int linger);
    request.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (linger) @(posedge clk);
  endtask

  task automatic set_plan(input logic [SIZE_W-1:0] size, input logic [COUNT_W-1:0] count);
    cfg_we <= 1'b1;
    cfg_index <= REG_DEST_SIZE;
    cfg_data <= size;
    @(posedge clk);
    cfg_index <= REG_SEGMENT_COUNT;
    cfg_data <= CFG_DATA_W'(count);
    @(posedge clk);
    cfg_we <= 1'b0;
    board.set_reg(REG_DEST_SIZE, size);
    board.set_reg(REG_SEGMENT_COUNT, CFG_DATA_W'(count));
  endtask

  initial begin : drain_side
    piece_t got;
    int     burst;
    int     hold;
    bit     hold_served;
    piece.ready = 1'b0;
    burst = 0;
    hold = 0;
    hold_served = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && piece.valid === 1'b1 && piece.ready === 1'b1) begin
        got.kind = piece.piece_kind;
        got.src_address = piece.src_address;
        got.out_position = piece.out_position;
        got.piece_bytes = piece.piece_bytes;
        got.total_bytes = piece.total_bytes;
        got.last = piece.last;
        board.check_piece(got);
      end
      if (hold_ask && !hold_served) begin
        hold = LONG_HOLD;
        hold_served = 1'b1;
      end
      if (hold > 0) begin
        hold--;
        piece.ready <= 1'b0;
      end else if (burst > 0) begin
        burst--;
        piece.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        burst = $urandom_range(1, 10) - 1;
        piece.ready <= 1'b0;
      end else begin
        piece.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (request.valid && request.ready) || (piece.valid && piece.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin : stimulus
    plan_shape_t        shape;
    off_t               base;
    off_t               at;
    off_t               seg_len;
    off_t               span;
    off_t               rel;
    logic [SIZE_W-1:0]  size;
    logic [COUNT_W-1:0] count;
    int                 phase;
    int                 segs;
    int                 reads;
    int                 pick;
    board = new();
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    request.valid = 1'b0;
    request.func = '0;
    request.entry_index = '0;
    request.entry_dst_offset = '0;
    request.entry_length = '0;
    request.entry_src_offset = '0;
    request.entry_is_pad = 1'b0;
    request.req_offset = '0;
    request.req_bytes = '0;
    quiet = 1'b0;
    hold_ask = 1'b0;
    items_sent = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_plan('0, '0);
    read_from_cursor(32'd64);
    drain(SETTLE_CYCLES);
    set_plan(48'd1000, '0);
    read_at(48'd5, 32'd10);
    load_entry(6'd0, 48'd0, 48'd100, 48'hFFFF_FFFF_FFF0, 1'b0);
    load_entry(6'd1, 48'd100, 48'd0, rand48(), 1'b0);
    load_entry(6'd2, 48'd100, 48'd200, rand48(), 1'b1);
    load_entry(6'd3, 48'd400, 48'd100, 48'd5000, 1'b0);
    drain(SETTLE_CYCLES);
    set_plan(48'd450, 7'd4);
    read_at(48'd20, 32'd500);
    read_at(48'd0, 32'd0);
    read_at(48'd450, 32'd10);
    read_at(48'd350, 32'd10);
    read_at(48'd420, 32'd100);
    read_at('1, '1);
    read_at(48'd0, '1);
    read_from_cursor(32'd50);
    read_from_cursor('1);
    read_from_cursor(32'd10);
    send_item(noise_req(FUNC_SPARE));

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      drain(SETTLE_CYCLES);
      pick = $urandom_range(0, 5);
      if (phase == 0) shape = PLAN_FINE;
      else shape = (pick < 4) ? PLAN_FINE : (pick == 4) ? PLAN_WIDE : PLAN_TOP;
      if (phase == 0) segs = MAX_SEGMENTS;
      else if (shape == PLAN_WIDE) segs = $urandom_range(1, 3);
      else segs = $urandom_range(1, 8);
      if (shape == PLAN_TOP) base = 48'hFFFF_FFFF_FFFF - 48'd3000;
      else if (board.cursor >= 64) base = board.cursor - off_t'($urandom_range(0, 63));
      else base = '0;

      at = base;
      for (int i = 0; i < segs; i++) begin
        if (shape != PLAN_WIDE && $urandom_range(0, 9) == 0) at += off_t'($urandom_range(1, 40));
        if (shape == PLAN_WIDE) begin
          seg_len = ($urandom_range(0, 3) == 0) ? '1 :
                    off_t'($urandom_range(32'hFFFF_FFFF, 32'h8000_0000));
        end else begin
          seg_len = ($urandom_range(0, 7) == 0) ? '0 : off_t'($urandom_range(1, 300));
        end
        load_entry(INDEX_W'(i), at, seg_len, rand48(), $urandom_range(0, 2) == 0);
        at += seg_len;
      end
      span = at - base;
      drain(SETTLE_CYCLES);

      pick = $urandom_range(0, 3);
      if (shape != PLAN_FINE || pick == 0) size = '1;
      else if (pick == 1) size = base + span / 2;
      else size = base + span;
      pick = $urandom_range(0, 7);
      if (phase == 0) count = '1;
      else if (pick == 0) count = COUNT_W'(MAX_SEGMENTS);
      else if (pick == 1) count = COUNT_W'($urandom);
      else count = COUNT_W'(segs);
      set_plan(size, count);
      if (phase == 2) hold_ask <= 1'b1;

      reads = $urandom_range(8, 14);
      for (int k = 0; k < reads; k++) begin
        case ($urandom_range(0, 19))
          12, 13, 14, 15: read_from_cursor(pick_bytes(shape));
          16: send_item(noise_req(FUNC_LOAD));
          17: send_item(noise_req(FUNC_SPARE));
          18: send_item(noise_req(FUNC_READ));
          19: drain(0);
          default: begin
            rel = (span == '0) ? '0 : rand48() % span;
            if ($urandom_range(0, 7) == 0) rel = span + off_t'($urandom_range(0, 20));
            read_at(base + rel, pick_bytes(shape));
          end
        endcase
      end
      phase++;
    end

    drain(TAIL_CYCLES);
    $display("covered %0d loads and %0d reads over %0d table plans", board.loads_seen,
             board.reads_seen, phase + 2);
    $display("checked %0d pieces, %0d field mismatches", board.pieces_seen, board.mismatches);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
